// ----- hw/rtl/spa_pkg.sv -----
// Types and codes shared by the slot pool allocator modules.
`default_nettype none

package spa_pkg;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_REUSED     = 3'd0,
    ST_APPENDED   = 3'd1,
    ST_POOL_FULL  = 3'd2,
    ST_BAD_INDEX  = 3'd3,
    ST_ALREADY_FREE = 3'd4
  } status_e;

  typedef struct packed {
    op_e        operation;
    logic [7:0] release_index;
  } req_t;

  typedef struct packed {
    logic [7:0] granted_index;
    status_e    status;
    logic [8:0] alive_count;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/spa_ram.sv -----
// Single-port-write, single-port-read memory with registered read data.
`default_nettype none

module spa_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output      logic [WIDTH-1:0]         rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/slot_pool_allocator.sv -----
// Top level of the slot pool allocator: request control, counters and memories.
//
// Usage: drive req_i and raise start; the request transaction is taken at a
// rising edge where start is high and busy is low. An allocate (operation 0)
// pops the most recently released slot, else appends a slot at the high-water
// mark, else reports the pool full. A release (operation 1) frees a live slot
// below the high-water mark and pushes it onto the free stack.
// Each request gives exactly one result transaction on rsp_o, marked by done_o
// for one cycle; acceptance moves the state to execute, and the result is then
// registered into rsp_o and done_o. busy is high for the one cycle in which
// the memory read data is consumed and written back, so no new request is
// taken in execute; the free-stack and alive-mark memories have registered reads.
// The result register is separate from the request side, so the next request
// is taken in the cycle its predecessor's result is shown. The receiver
// cannot stall. Reset clears the counters and control at once; the alive marks
// need no clearing pass since a slot at or above the high-water mark reads as
// free and every slot below it was written when appended.
`default_nettype none

module slot_pool_allocator #(
  parameter int unsigned SLOTS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire spa_pkg::req_t req_i,
  output      logic        busy,
  output      logic        done_o,
  output      spa_pkg::rsp_t rsp_o
);

  import spa_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned CMP_W = (CNT_W > 8) ? CNT_W : 8;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] depth_q, depth_d;
  logic [CNT_W-1:0] hw_q, hw_d;
  logic [CNT_W-1:0] live_q, live_d;
  op_e              op_q;
  logic [7:0]       rel_q;
  logic             done_q;
  rsp_t             rsp_q, rsp_d;

  logic             accept;
  logic [IDX_W-1:0] stk_rd_data;
  logic             stk_rd_en;
  logic             stk_wr_en;
  logic [0:0]       mark_rd_data;
  logic             mark_wr_en;
  logic [IDX_W-1:0] mark_wr_addr;
  logic [0:0]       mark_wr_data;
  logic [IDX_W-1:0] grant_idx;
  logic             rel_bad;

  assign accept    = start && !busy;
  assign busy      = (state_q == S_EXEC);
  assign stk_rd_en = accept && (req_i.operation == OP_ALLOC) && (depth_q != '0);
  assign rel_bad   = CMP_W'(rel_q) >= CMP_W'(hw_q);

  spa_ram #(.DEPTH(SLOTS), .WIDTH(IDX_W)) u_free_stack (
    .clk_i    (clk_i),
    .rd_en_i  (stk_rd_en),
    .rd_addr_i(IDX_W'(depth_q - CNT_W'(1))),
    .rd_data_o(stk_rd_data),
    .wr_en_i  (stk_wr_en),
    .wr_addr_i(IDX_W'(depth_q)),
    .wr_data_i(IDX_W'(rel_q))
  );

  spa_ram #(.DEPTH(SLOTS), .WIDTH(1)) u_alive_marks (
    .clk_i    (clk_i),
    .rd_en_i  (accept),
    .rd_addr_i(IDX_W'(req_i.release_index)),
    .rd_data_o(mark_rd_data),
    .wr_en_i  (mark_wr_en),
    .wr_addr_i(mark_wr_addr),
    .wr_data_i(mark_wr_data)
  );

  always_comb begin
    state_d      = state_q;
    depth_d      = depth_q;
    hw_d         = hw_q;
    live_d       = live_q;
    stk_wr_en    = 1'b0;
    mark_wr_en   = 1'b0;
    mark_wr_addr = IDX_W'(rel_q);
    mark_wr_data = 1'b0;
    grant_idx    = '0;
    rsp_d        = rsp_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        rsp_d.status = ST_REUSED;
        if (op_q == OP_ALLOC) begin
          priority if (depth_q != '0) begin
            grant_idx    = stk_rd_data;
            depth_d      = depth_q - CNT_W'(1);
            mark_wr_en   = 1'b1;
            mark_wr_addr = stk_rd_data;
            mark_wr_data = 1'b1;
            live_d       = live_q + CNT_W'(1);
            rsp_d.status = ST_REUSED;
          end else if (hw_q != CNT_W'(SLOTS)) begin
            grant_idx    = IDX_W'(hw_q);
            hw_d         = hw_q + CNT_W'(1);
            mark_wr_en   = 1'b1;
            mark_wr_addr = IDX_W'(hw_q);
            mark_wr_data = 1'b1;
            live_d       = live_q + CNT_W'(1);
            rsp_d.status = ST_APPENDED;
          end else begin
            rsp_d.status = ST_POOL_FULL;
          end
        end else begin
          priority if (rel_bad) begin
            rsp_d.status = ST_BAD_INDEX;
          end else if (mark_rd_data == 1'b0) begin
            rsp_d.status = ST_ALREADY_FREE;
          end else begin
            mark_wr_en   = 1'b1;
            mark_wr_data = 1'b0;
            if (depth_q != CNT_W'(SLOTS)) begin
              stk_wr_en = 1'b1;
              depth_d   = depth_q + CNT_W'(1);
            end
            if (live_q != '0) begin
              live_d = live_q - CNT_W'(1);
            end
            rsp_d.status = ST_REUSED;
          end
        end
        rsp_d.granted_index = 8'(grant_idx);
        rsp_d.alive_count   = 9'(live_d);
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      depth_q <= '0;
      hw_q    <= '0;
      live_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      hw_q    <= hw_d;
      live_q  <= live_d;
      done_q  <= (state_q == S_EXEC);
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (accept) begin
      op_q  <= req_i.operation;
      rel_q <= req_i.release_index;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_EXEC))
    else $error("result without a preceding execute cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not enter execute");

  a_pool_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, depth_q} + {1'b0, live_q}) == {1'b0, hw_q})
    else $error("free stack and live count do not cover the high-water mark");

  a_hw_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q >= $past(hw_q))
    else $error("high-water mark decreased");

  a_no_mark_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mark_wr_en || stk_wr_en) |-> (state_q == S_EXEC))
    else $error("memory write outside execute");

endmodule

`default_nettype wire

// ----- bench/slot_pool_allocator_tb.sv -----
// Self-checking testbench for the slot pool allocator: directed table, fill to pool full, then random traffic.
`default_nettype none

module slot_pool_allocator_tb;
  import spa_pkg::*;

  localparam int unsigned SLOTS = 256;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 440;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic done_o;
  req_t req_i;
  rsp_t rsp_o;

  logic [7:0]       free_ids [SLOTS];
  logic [8:0]       free_depth = '0;
  logic [8:0]       high_mark = '0;
  logic [8:0]       live_cnt = '0;
  logic [SLOTS-1:0] alive_bits = '0;

  rsp_t pending_rsp [$];
  row_t dir_rows [$];
  rsp_t want_rsp;
  int   errors = 0;
  int   cycles = 0;
  int   accepted = 0;
  int   status_cnt [5] = '{default: 0};
  bit   idle_en = 1'b1;

  slot_pool_allocator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic rsp_t predict_slot(req_t r);
    rsp_t o;
    o = '0;
    if (r.operation == OP_ALLOC) begin
      if (free_depth != '0) begin
        free_depth = free_depth - 9'd1;
        o.granted_index = free_ids[free_depth[7:0]];
        alive_bits[o.granted_index] = 1'b1;
        live_cnt = live_cnt + 9'd1;
        o.status = ST_REUSED;
      end else if (high_mark < 9'(SLOTS)) begin
        o.granted_index = high_mark[7:0];
        alive_bits[high_mark[7:0]] = 1'b1;
        high_mark = high_mark + 9'd1;
        live_cnt = live_cnt + 9'd1;
        o.status = ST_APPENDED;
      end else begin
        o.status = ST_POOL_FULL;
      end
    end else if ({1'b0, r.release_index} >= high_mark) begin
      o.status = ST_BAD_INDEX;
    end else if (!alive_bits[r.release_index]) begin
      o.status = ST_ALREADY_FREE;
    end else begin
      alive_bits[r.release_index] = 1'b0;
      free_ids[free_depth[7:0]] = r.release_index;
      free_depth = free_depth + 9'd1;
      live_cnt = live_cnt - 9'd1;
      o.status = ST_REUSED;
    end
    o.alive_count = live_cnt;
    return o;
  endfunction

  function automatic req_t rand_req(int alloc_pct);
    req_t r;
    int   pick;
    r.operation = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_RELEASE;
    pick = $urandom_range(0, 99);
    if (r.operation == OP_RELEASE && pick < 55 && high_mark != 0) begin
      r.release_index = 8'($urandom_range(0, high_mark - 1));
    end else if (r.operation == OP_RELEASE && pick < 70 && free_depth != 0) begin
      r.release_index = free_ids[8'(free_depth - 9'd1)];
    end else begin
      r.release_index = 8'($urandom_range(0, 255));
    end
    return r;
  endfunction

  task automatic add_row(op_e op, logic [7:0] idx, bit typed, logic [7:0] gi, status_e st,
                         logic [8:0] ac);
    row_t row;
    row.req.operation = op;
    row.req.release_index = idx;
    row.typed = typed;
    row.want.granted_index = gi;
    row.want.status = st;
    row.want.alive_count = ac;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic issue(req_t r, bit typed, rsp_t want);
    rsp_t pred;
    while (idle_en && $urandom_range(0, 99) < 38) begin
      start <= 1'b0;
      req_i.operation <= op_e'($urandom_range(0, 1));
      req_i.release_index <= 8'($urandom_range(0, 255));
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pred = predict_slot(r);
    status_cnt[pred.status]++;
    accepted++;
    pending_rsp.insert(pending_rsp.size(), typed ? want : pred);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [8:0] want, logic [8:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got index %0d status %0d alive %0d",
                 $time, rsp_o.granted_index, rsp_o.status, rsp_o.alive_count);
      end else begin
        want_rsp = pending_rsp.pop_front();
        check_field("granted_index", 9'(want_rsp.granted_index), 9'(rsp_o.granted_index));
        check_field("status", 9'(want_rsp.status), 9'(rsp_o.status));
        check_field("alive_count", want_rsp.alive_count, rsp_o.alive_count);
      end
    end
  end

  initial begin : stimulus
    int   bias;
    req_t fill_req;
    rst_ni <= 1'b0;
    start <= 1'b0;
    req_i <= '0;

    add_row(OP_RELEASE, 8'd0,   1'b1, 8'd0, ST_BAD_INDEX,    9'd0);
    add_row(OP_RELEASE, 8'd255, 1'b1, 8'd0, ST_BAD_INDEX,    9'd0);
    add_row(OP_ALLOC,   8'd255, 1'b1, 8'd0, ST_APPENDED,     9'd1);
    add_row(OP_ALLOC,   8'd0,   1'b1, 8'd1, ST_APPENDED,     9'd2);
    add_row(OP_RELEASE, 8'd1,   1'b1, 8'd0, ST_REUSED,       9'd1);
    add_row(OP_RELEASE, 8'd1,   1'b1, 8'd0, ST_ALREADY_FREE, 9'd1);
    add_row(OP_RELEASE, 8'd2,   1'b1, 8'd0, ST_BAD_INDEX,    9'd1);
    add_row(OP_ALLOC,   8'd0,   1'b1, 8'd1, ST_REUSED,       9'd2);
    add_row(OP_RELEASE, 8'd0,   1'b0, 8'd0, ST_REUSED,       9'd0);
    add_row(OP_RELEASE, 8'd1,   1'b0, 8'd0, ST_REUSED,       9'd0);
    add_row(OP_ALLOC,   8'd170, 1'b0, 8'd0, ST_REUSED,       9'd0);
    add_row(OP_ALLOC,   8'd85,  1'b0, 8'd0, ST_REUSED,       9'd0);
    add_row(OP_ALLOC,   8'd0,   1'b0, 8'd0, ST_REUSED,       9'd0);
    add_row(OP_RELEASE, 8'd2,   1'b0, 8'd0, ST_REUSED,       9'd0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    drain();

    fill_req.operation = OP_ALLOC;
    while (high_mark < 9'(SLOTS) || status_cnt[ST_POOL_FULL] < 3) begin
      fill_req.release_index = 8'($urandom_range(0, 255));
      issue(fill_req, 1'b0, '0);
    end

    bias = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: bias = 85;
          1: bias = 50;
          default: bias = 15;
        endcase
      end
      idle_en = !(n >= 250 && n < 370);
      if (n == 200) drain();
      issue(rand_req(bias), 1'b0, '0);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("summary: %0d requests, %0d reused, %0d appended, %0d pool full,",
             accepted, status_cnt[ST_REUSED], status_cnt[ST_APPENDED],
             status_cnt[ST_POOL_FULL]);
    $display("summary: %0d bad index, %0d already free, %0d mismatches",
             status_cnt[ST_BAD_INDEX], status_cnt[ST_ALREADY_FREE], errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
